// ----- rtl/hsam_pkg.sv -----
`timescale 1ns / 1ps

package hsam_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // input tdata: light | temp | press | now, padded to whole bytes
  localparam int IN_USED_BITS  = 2 * SAMPLE_BITS + 1 + TIME_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
  localparam int OUT_USED_BITS = 10;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_DARK_ENTER   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DARK_EXIT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_ENTER = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_EXIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_ENTER    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_EXIT     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_PERIOD = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEEP_PERIOD  = 3'd7;

  localparam logic [SAMPLE_BITS-1:0] RST_DARK_ENTER   = SAMPLE_BITS'(700);
  localparam logic [SAMPLE_BITS-1:0] RST_DARK_EXIT    = SAMPLE_BITS'(900);
  localparam logic [SAMPLE_BITS-1:0] RST_BRIGHT_ENTER = SAMPLE_BITS'(2500);
  localparam logic [SAMPLE_BITS-1:0] RST_BRIGHT_EXIT  = SAMPLE_BITS'(2200);
  localparam logic [SAMPLE_BITS-1:0] RST_HOT_ENTER    = SAMPLE_BITS'(2200);
  localparam logic [SAMPLE_BITS-1:0] RST_HOT_EXIT     = SAMPLE_BITS'(2000);
  localparam logic [PERIOD_BITS-1:0] RST_BLINK_PERIOD = PERIOD_BITS'(300);
  localparam logic [PERIOD_BITS-1:0] RST_BEEP_PERIOD  = PERIOD_BITS'(1500);

  typedef enum logic [1:0] {
    MODE_CALM  = 2'd0,
    MODE_HEAT  = 2'd1,
    MODE_STORM = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LUX_DIM    = 2'd0,
    LUX_MID    = 2'd1,
    LUX_BRIGHT = 2'd2
  } light_t;

  // LED pattern: bit0 normal, bit1 heat, bit2 storm
  typedef logic [2:0] led_t;

  typedef struct packed {
    logic   beep;
    led_t   leds;
    logic   alert;
    logic   hot;
    light_t light_class;
    mode_t  mode;
  } result_t;

  function automatic led_t steady_leds(mode_t m);
    led_t l;
    case (m)
      MODE_CALM:  l = 3'b001;
      MODE_HEAT:  l = 3'b010;
      MODE_STORM: l = 3'b100;
      default:    l = 3'b000;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/hysteresis_sensor_alert_monitor_top.sv -----
`timescale 1ns / 1ps

// Sensor alert monitor: one input transaction per monitoring pass.
//
// in_*  : pass transaction. in_tdata carries, from bit 0 up: light_sample,
//         temp_sample, button_press, now_ms, then zero padding.
// out_* : result transaction, one per pass. out_tdata carries, from bit 0
//         up: mode_now, light_class, hot_flag, alert_on, led_normal_on,
//         led_heat_on, led_storm_on, beep_pulse, then zero padding.
// cfg_* : register write, index 0..7 (dark enter/exit, bright enter/exit,
//         hot enter/exit, blink period, beep period). Always ready; write
//         only while no pass is in flight.
//
// The pass is evaluated combinationally from the
// transaction and the mode/hysteresis/timer registers, and the state and
// the result register update on the accepting edge. Throughput is one
// pass per cycle while the receiver keeps up, bounded by that single state update loop.
// A stalled receiver holds the result register; in_tready drops only when
// a result is waiting and out_tready is low, so nothing is lost.
// Reset restores the default thresholds and periods, normal mode, normal
// light, not hot, steady normal LED, and clears both interval timestamps.
module hysteresis_sensor_alert_monitor_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // light_sample, temp_sample, button_press, now_ms
  input  logic [hsam_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode_now, light_class, hot_flag, alert_on, led_normal_on,
  // led_heat_on, led_storm_on, beep_pulse
  output logic [hsam_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsam_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hsam_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import hsam_pkg::*;

  // configuration registers
  logic [SAMPLE_BITS-1:0] dark_enter_r, dark_exit_r, bright_enter_r, bright_exit_r;
  logic [SAMPLE_BITS-1:0] hot_enter_r, hot_exit_r;
  logic [PERIOD_BITS-1:0] blink_period_r, beep_period_r;

  // pass state
  mode_t                mode_r, mode_nxt;
  light_t               light_r, light_nxt;
  logic                 hot_r, hot_nxt;
  logic                 phase_r, phase_nxt;
  led_t                 led_r, led_nxt;
  logic [TIME_BITS-1:0] last_blink_r, last_blink_nxt;
  logic [TIME_BITS-1:0] last_beep_r, last_beep_nxt;

  result_t res_r, res_nxt;
  logic    out_valid_r;

  // unpacked pass fields
  logic [SAMPLE_BITS-1:0] light_s, temp_s;
  logic                   press;
  logic [TIME_BITS-1:0]   now_s;
  logic [TIME_BITS-1:0]   blink_gap, beep_gap;
  logic                   in_acc;
  mode_t                  mode_p;
  logic                   phase_p, alert, blink_due, beep_due, beep;
  led_t                   led_p;

  assign light_s = in_tdata[SAMPLE_BITS-1:0];
  assign temp_s  = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign press   = in_tdata[2*SAMPLE_BITS];
  assign now_s   = in_tdata[2*SAMPLE_BITS+1 +: TIME_BITS];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // gaps wrap modulo 2^TIME_BITS
  assign blink_gap = now_s - last_blink_r;
  assign beep_gap  = now_s - last_beep_r;

  always_comb begin
    // button first: advance mode, clear blink phase, show steady LED
    mode_p  = mode_r;
    phase_p = phase_r;
    led_p   = led_r;
    beep    = 1'b0;
    if (press) begin
      case (mode_r)
        MODE_CALM: mode_p = MODE_HEAT;
        MODE_HEAT: mode_p = MODE_STORM;
        default:   mode_p = MODE_CALM;
      endcase
      phase_p = 1'b0;
      led_p   = steady_leds(mode_p);
      beep    = 1'b1;
    end

    // light hysteresis: low and high classes each hold until their exit level
    case (light_r)
      LUX_DIM: begin
        if (light_s > dark_exit_r) begin
          light_nxt = (light_s > bright_enter_r) ? LUX_BRIGHT : LUX_MID;
        end else begin
          light_nxt = LUX_DIM;
        end
      end
      LUX_BRIGHT: begin
        if (light_s < bright_exit_r) begin
          light_nxt = (light_s < dark_enter_r) ? LUX_DIM : LUX_MID;
        end else begin
          light_nxt = LUX_BRIGHT;
        end
      end
      default: begin
        if (light_s < dark_enter_r) begin
          light_nxt = LUX_DIM;
        end else if (light_s > bright_enter_r) begin
          light_nxt = LUX_BRIGHT;
        end else begin
          light_nxt = LUX_MID;
        end
      end
    endcase

    hot_nxt = hot_r ? !(temp_s < hot_exit_r) : (temp_s > hot_enter_r);

    alert = ((mode_p == MODE_HEAT) && ((light_nxt == LUX_BRIGHT) || hot_nxt)) ||
            ((mode_p == MODE_STORM) && (light_nxt == LUX_DIM));

    blink_due = blink_gap >= TIME_BITS'(blink_period_r);
    beep_due  = beep_gap  >= TIME_BITS'(beep_period_r);

    mode_nxt       = mode_p;
    phase_nxt      = phase_p;
    led_nxt        = led_p;
    last_blink_nxt = last_blink_r;
    last_beep_nxt  = last_beep_r;
    if (alert) begin
      // toggle only the current mode's LED; between toggles hold the pattern
      if (blink_due) begin
        phase_nxt      = !phase_p;
        led_nxt        = (!phase_p && (mode_p != MODE_CALM)) ? steady_leds(mode_p) : 3'b000;
        last_blink_nxt = now_s;
      end
      if (beep_due) begin
        beep          = 1'b1;
        last_beep_nxt = now_s;
      end
    end else begin
      led_nxt = steady_leds(mode_p);
    end

    res_nxt.mode        = mode_nxt;
    res_nxt.light_class = light_nxt;
    res_nxt.hot         = hot_nxt;
    res_nxt.alert       = alert;
    res_nxt.leds        = led_nxt;
    res_nxt.beep        = beep;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_enter_r   <= RST_DARK_ENTER;
      dark_exit_r    <= RST_DARK_EXIT;
      bright_enter_r <= RST_BRIGHT_ENTER;
      bright_exit_r  <= RST_BRIGHT_EXIT;
      hot_enter_r    <= RST_HOT_ENTER;
      hot_exit_r     <= RST_HOT_EXIT;
      blink_period_r <= RST_BLINK_PERIOD;
      beep_period_r  <= RST_BEEP_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DARK_ENTER:   dark_enter_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_DARK_EXIT:    dark_exit_r    <= cfg_data[SAMPLE_BITS-1:0];
        REG_BRIGHT_ENTER: bright_enter_r <= cfg_data[SAMPLE_BITS-1:0];
        REG_BRIGHT_EXIT:  bright_exit_r  <= cfg_data[SAMPLE_BITS-1:0];
        REG_HOT_ENTER:    hot_enter_r    <= cfg_data[SAMPLE_BITS-1:0];
        REG_HOT_EXIT:     hot_exit_r     <= cfg_data[SAMPLE_BITS-1:0];
        REG_BLINK_PERIOD: blink_period_r <= cfg_data[PERIOD_BITS-1:0];
        REG_BEEP_PERIOD:  beep_period_r  <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pass state advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CALM;
      light_r      <= LUX_MID;
      hot_r        <= 1'b0;
      phase_r      <= 1'b0;
      led_r        <= steady_leds(MODE_CALM);
      last_blink_r <= '0;
      last_beep_r  <= '0;
    end else if (in_acc) begin
      mode_r       <= mode_nxt;
      light_r      <= light_nxt;
      hot_r        <= hot_nxt;
      phase_r      <= phase_nxt;
      led_r        <= led_nxt;
      last_blink_r <= last_blink_nxt;
      last_beep_r  <= last_beep_nxt;
    end
  end

  // result register: load on accept, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(res_r);

endmodule

// ----- rtl/hsam_checker.sv -----
`timescale 1ns / 1ps

module hsam_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [hsam_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import hsam_pkg::*;

  // every accepted pass yields a result on the next cycle
  a_pass_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted pass produced no result");

  // a stalled result keeps its value
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // input is only blocked by a waiting result
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty result register");

  // without alert exactly one steady LED; with alert at most one
  a_led_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5] ? $onehot0(out_tdata[8:6]) : $onehot(out_tdata[8:6])))
    else $error("bad LED pattern");

  // alert never raised in normal mode
  a_no_alert_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == MODE_CALM)) |-> !out_tdata[5])
    else $error("alert in normal mode");

endmodule

bind hysteresis_sensor_alert_monitor_top hsam_checker u_hsam_checker (.*);

// ----- tb/sv/hysteresis_sensor_alert_monitor_top_test.sv -----
`timescale 1ns / 1ps

module hysteresis_sensor_alert_monitor_top_test;
  import hsam_pkg::*;

  // Generous ceiling: ~1600 passes, plus holds and drains.
  localparam int CYCLE_LIMIT       = 500000;
  localparam int LONG_HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES     = 4;

  logic                     clk;
  logic                     rst_n;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  hysteresis_sensor_alert_monitor_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predicted monitor state and settings, updated on every accepted transaction.
  logic [SAMPLE_BITS-1:0] dark_enter, dark_exit, bright_enter, bright_exit;
  logic [SAMPLE_BITS-1:0] hot_enter, hot_exit;
  logic [PERIOD_BITS-1:0] blink_period, beep_period;
  mode_t                  cur_mode;
  light_t                 cur_light;
  logic                   cur_hot;
  logic                   cur_phase;
  led_t                   cur_leds;
  logic [TIME_BITS-1:0]   last_blink, last_beep;

  // Results still owed by the block, oldest first.
  result_t                pass_results_due[$];

  logic [TIME_BITS-1:0]   wall_ms;
  logic                   idling;
  logic                   hold_results;
  int                     mismatches;
  int                     cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Steady LED of a mode: bit0 normal, bit1 heat, bit2 storm.
  function automatic led_t mode_led(mode_t m);
    led_t l;
    case (m)
      MODE_CALM:  l = 3'b001;
      MODE_HEAT:  l = 3'b010;
      MODE_STORM: l = 3'b100;
      default:    l = 3'b000;
    endcase
    return l;
  endfunction

  task automatic reset_monitor_model();
    dark_enter   = RST_DARK_ENTER;
    dark_exit    = RST_DARK_EXIT;
    bright_enter = RST_BRIGHT_ENTER;
    bright_exit  = RST_BRIGHT_EXIT;
    hot_enter    = RST_HOT_ENTER;
    hot_exit     = RST_HOT_EXIT;
    blink_period = RST_BLINK_PERIOD;
    beep_period  = RST_BEEP_PERIOD;
    cur_mode     = MODE_CALM;
    cur_light    = LUX_MID;
    cur_hot      = 1'b0;
    cur_phase    = 1'b0;
    cur_leds     = mode_led(MODE_CALM);
    last_blink   = '0;
    last_beep    = '0;
  endtask

  // Advance the predicted monitor by one pass and return what it shows.
  function automatic result_t evaluate_pass(logic [SAMPLE_BITS-1:0] light,
                                            logic [SAMPLE_BITS-1:0] temp,
                                            logic press, logic [TIME_BITS-1:0] now);
    result_t r;
    logic    beep;
    logic    alert;
    beep  = 1'b0;
    alert = 1'b0;
    // Button first: step the mode round, restart the blink, show steady LED.
    if (press) begin
      cur_mode  = (cur_mode >= MODE_STORM) ? MODE_CALM : mode_t'(cur_mode + 2'd1);
      cur_phase = 1'b0;
      cur_leds  = mode_led(cur_mode);
      beep      = 1'b1;
    end
    // Light classification with separate enter and exit levels per band.
    case (cur_light)
      LUX_DIM: begin
        if (light > dark_exit)
          cur_light = (light > bright_enter) ? LUX_BRIGHT : LUX_MID;
      end
      LUX_BRIGHT: begin
        if (light < bright_exit)
          cur_light = (light < dark_enter) ? LUX_DIM : LUX_MID;
      end
      default: begin
        if (light < dark_enter)        cur_light = LUX_DIM;
        else if (light > bright_enter) cur_light = LUX_BRIGHT;
        else                           cur_light = LUX_MID;
      end
    endcase
    cur_hot = cur_hot ? !(temp < hot_exit) : (temp > hot_enter);
    if (cur_mode == MODE_HEAT && (cur_light == LUX_BRIGHT || cur_hot)) alert = 1'b1;
    if (cur_mode == MODE_STORM && cur_light == LUX_DIM) alert = 1'b1;
    if (alert) begin
      // Intervals wrap with the timestamp; a zero period elapses every pass.
      if (TIME_BITS'(now - last_blink) >= TIME_BITS'(blink_period)) begin
        cur_phase  = ~cur_phase;
        cur_leds   = (cur_phase && cur_mode != MODE_CALM) ? mode_led(cur_mode) : 3'b000;
        last_blink = now;
      end
      if (TIME_BITS'(now - last_beep) >= TIME_BITS'(beep_period)) begin
        beep      = 1'b1;
        last_beep = now;
      end
    end else begin
      cur_leds = mode_led(cur_mode);
    end
    r.mode        = cur_mode;
    r.light_class = cur_light;
    r.hot         = cur_hot;
    r.alert       = alert;
    r.leds        = cur_leds;
    r.beep        = beep;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one pass transaction, optionally after an idle burst; leave tvalid high.
  task automatic send_pass(input logic [SAMPLE_BITS-1:0] light,
                           input logic [SAMPLE_BITS-1:0] temp,
                           input logic press, input logic [TIME_BITS-1:0] now);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'({now, press, temp, light});
    do @(posedge clk); while (!in_tready);
    pass_results_due.push_back(evaluate_pass(light, temp, press, now));
  endtask

  // Drop the offer and hold until every owed result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pass_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // Thresholds keep their low sample bits, periods the full word.
    case (idx)
      REG_DARK_ENTER:   dark_enter   = value[SAMPLE_BITS-1:0];
      REG_DARK_EXIT:    dark_exit    = value[SAMPLE_BITS-1:0];
      REG_BRIGHT_ENTER: bright_enter = value[SAMPLE_BITS-1:0];
      REG_BRIGHT_EXIT:  bright_exit  = value[SAMPLE_BITS-1:0];
      REG_HOT_ENTER:    hot_enter    = value[SAMPLE_BITS-1:0];
      REG_HOT_EXIT:     hot_exit     = value[SAMPLE_BITS-1:0];
      REG_BLINK_PERIOD: blink_period = value[PERIOD_BITS-1:0];
      REG_BEEP_PERIOD:  beep_period  = value[PERIOD_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_BITS-1:0] de, dx, be, bx, he, hx,
                             input logic [CFG_DATA_BITS-1:0] blink, beep);
    wait_for_results();
    write_reg(REG_DARK_ENTER, de);
    write_reg(REG_DARK_EXIT, dx);
    write_reg(REG_BRIGHT_ENTER, be);
    write_reg(REG_BRIGHT_EXIT, bx);
    write_reg(REG_HOT_ENTER, he);
    write_reg(REG_HOT_EXIT, hx);
    write_reg(REG_BLINK_PERIOD, blink);
    write_reg(REG_BEEP_PERIOD, beep);
  endtask

  // Pick a sample mostly hugging a threshold, sometimes anywhere or at an end.
  function automatic logic [SAMPLE_BITS-1:0] sample_near(logic [SAMPLE_BITS-1:0] level);
    int v;
    case ($urandom_range(0, 4))
      0:       v = $urandom_range(0, 4095);
      1:       v = ($urandom_range(0, 1) == 0) ? 0 : 4095;
      default: v = int'(level) + int'($urandom_range(0, 6)) - 3;
    endcase
    if (v < 0)    v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_random_pass();
    logic [SAMPLE_BITS-1:0] lux_ref;
    logic [SAMPLE_BITS-1:0] temp_level;
    case ($urandom_range(0, 3))
      0:       lux_ref = dark_enter;
      1:       lux_ref = dark_exit;
      2:       lux_ref = bright_enter;
      default: lux_ref = bright_exit;
    endcase
    temp_level = ($urandom_range(0, 1) == 0) ? hot_enter : hot_exit;
    // Advance time mostly in steps near the periods, now and then jump or stand still.
    case ($urandom_range(0, 19))
      0:       wall_ms = $urandom;
      1:       ;
      default: wall_ms = wall_ms + $urandom_range(1, 500);
    endcase
    send_pass(sample_near(lux_ref), sample_near(temp_level),
              ($urandom_range(0, 7) == 0), wall_ms);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] random_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_BITS'($urandom_range(1, 800));
    endcase
  endfunction

  // Walk the hysteresis edges, mode steps, blink and beep timing and the time wrap.
  task automatic test_directed();
    send_pass(12'd0,    12'd0,    1'b0, 32'd0);
    send_pass(12'd4095, 12'd4095, 1'b0, 32'hFFFF_FFFF);
    send_pass(12'd2300, 12'd2100, 1'b1, 32'd10);
    send_pass(12'd2199, 12'd1999, 1'b0, 32'd400);
    send_pass(12'd2501, 12'd2000, 1'b0, 32'd700);
    send_pass(12'd2501, 12'd2000, 1'b0, 32'd900);
    send_pass(12'd2501, 12'd2000, 1'b0, 32'd1000);
    send_pass(12'd2501, 12'd2000, 1'b0, 32'd1500);
    send_pass(12'd2500, 12'd2201, 1'b1, 32'd1600);
    send_pass(12'd699,  12'd0,    1'b0, 32'd1700);
    send_pass(12'd900,  12'd0,    1'b0, 32'd1800);
    send_pass(12'd901,  12'd0,    1'b0, 32'd1900);
    send_pass(12'd0,    12'd0,    1'b0, 32'hFFFF_FF00);
    send_pass(12'd0,    12'd0,    1'b0, 32'h0000_0010);
    send_pass(12'd0,    12'd0,    1'b0, 32'h0000_0040);
    send_pass(12'd0,    12'd0,    1'b1, 32'h0000_0050);
    send_pass(12'd2600, 12'd0,    1'b1, 32'h0000_0060);
    send_pass(12'd3000, 12'd0,    1'b0, 32'h0000_0400);
    send_pass(12'd2201, 12'd0,    1'b1, 32'h0000_0500);
    send_pass(12'd1000, 12'd0,    1'b1, 32'h0000_0600);
    wait_for_results();
  endtask

  // Extreme settings: all zero (every alert pass toggles and beeps), all ones, then a mix.
  task automatic test_config_extremes();
    load_config('0, '0, '0, '0, '0, '0, '0, '0);
    repeat (100) send_random_pass();
    load_config('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (100) send_random_pass();
    load_config('0, '1, '1, '0, '1, '0, '0, '1);
    repeat (100) send_random_pass();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        load_config(CFG_DATA_BITS'(RST_DARK_ENTER), CFG_DATA_BITS'(RST_DARK_EXIT),
                    CFG_DATA_BITS'(RST_BRIGHT_ENTER), CFG_DATA_BITS'(RST_BRIGHT_EXIT),
                    CFG_DATA_BITS'(RST_HOT_ENTER), CFG_DATA_BITS'(RST_HOT_EXIT),
                    CFG_DATA_BITS'(RST_BLINK_PERIOD), CFG_DATA_BITS'(RST_BEEP_PERIOD));
      end else begin
        load_config(CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)),
                    random_period(), random_period());
      end
      // Start some phases just short of the timestamp wrap.
      if (phase % 3 == 1) wall_ms = 32'hFFFF_F000;
      repeat (110) send_random_pass();
    end
  endtask

  // Hold the receiver off for a long stretch while passes keep coming.
  task automatic test_result_backpressure();
    hold_results = 1'b1;
    repeat (60) send_random_pass();
  endtask

  // Pause the sender until every result is home, several times over.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (40) send_random_pass();
      wait_for_results();
    end
  endtask

  // Close with back-to-back traffic and no idling on either side.
  task automatic test_steady_traffic();
    idling = 1'b0;
    repeat (200) send_random_pass();
  endtask

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest prediction, field by field.
  initial begin : result_check
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = result_t'(out_tdata[OUT_USED_BITS-1:0]);
        if (pass_results_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 0);
        end else begin
          want = pass_results_due.pop_front();
          if (got.mode != want.mode)
            report_mismatch("mode_now", 32'(got.mode), 32'(want.mode));
          if (got.light_class != want.light_class)
            report_mismatch("light_class", 32'(got.light_class), 32'(want.light_class));
          if (got.hot != want.hot)
            report_mismatch("hot_flag", 32'(got.hot), 32'(want.hot));
          if (got.alert != want.alert)
            report_mismatch("alert_on", 32'(got.alert), 32'(want.alert));
          if (got.leds[0] != want.leds[0])
            report_mismatch("led_normal_on", 32'(got.leds[0]), 32'(want.leds[0]));
          if (got.leds[1] != want.leds[1])
            report_mismatch("led_heat_on", 32'(got.leds[1]), 32'(want.leds[1]));
          if (got.leds[2] != want.leds[2])
            report_mismatch("led_storm_on", 32'(got.leds[2]), 32'(want.leds[2]));
          if (got.beep != want.beep)
            report_mismatch("beep_pulse", 32'(got.beep), 32'(want.beep));
          if (out_tdata[OUT_DATA_BITS-1:OUT_USED_BITS] != '0)
            report_mismatch("padding", 32'(out_tdata[OUT_DATA_BITS-1:OUT_USED_BITS]), 0);
        end
      end
    end
  end

  // Abandon a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hysteresis_sensor_alert_monitor_top_test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DARK_ENTER;
    cfg_data  <= '0;
    idling       = 1'b1;
    hold_results = 1'b0;
    mismatches   = 0;
    wall_ms      = '0;
    reset_monitor_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_settings();
    test_result_backpressure();
    test_drain_pause();
    test_steady_traffic();
    wait_for_results();

    if (mismatches == 0) begin
      $display("hysteresis_sensor_alert_monitor_top_test passed");
    end else begin
      $display("hysteresis_sensor_alert_monitor_top_test failed");
    end
    $finish;
  end

endmodule
